[hdl/vwd_pkg.sv]
// Shared types and constants for the varint word decoder.
// Used by vwd_lane, vwd_merge and varint_word_decoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vwd_pkg;

    localparam int BYTE_BITS        = 8;
    localparam int WORD_BYTES       = 8;
    localparam int PAYLOAD_BITS     = 7;
    localparam int MAX_VARINT_BYTES = 5;

    localparam logic [6:0] PAYLOAD_MASK = 7'h7F;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERLONG = 2'd1;
    localparam logic [1:0] STATUS_CUTOFF   = 2'd2;

    typedef struct packed {
        logic [63:0] data_bytes;
        logic [3:0]  byte_count;
        logic        end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [31:0] decoded_value;
        logic [1:0]  status;
        logic        last_of_word;
    } out_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  seen;
        logic        ovf;
    } varint_state_t;

    typedef struct packed {
        logic          term;
        varint_state_t acc;
    } lane_result_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } entry_t;

endpackage

`default_nettype wire

[hdl/vwd_lane.sv]
// One decode lane: accumulates the varint that runs through byte IDX of the word.
// Depends on vwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vwd_lane #(
    parameter int IDX = 0
) (
    input  wire logic [63:0]           data_bytes,
    input  wire logic [3:0]            byte_count,
    input  wire vwd_pkg::varint_state_t carry_in,
    output vwd_pkg::lane_result_t      result
);

    always_comb begin
        logic       carry;
        logic [3:0] start;
        logic [3:0] raw;
        logic [2:0] pos;
        logic [6:0] payload;
        logic [5:0] shamt;

        carry   = 1'b1;
        start   = '0;
        raw     = '0;
        payload = '0;
        shamt   = '0;
        for (int k = 0; k < IDX; k++) begin
            if (!data_bytes[vwd_pkg::BYTE_BITS * k + 7]) begin
                carry = 1'b0;
                start = 4'(k + 1);
            end
        end

        result.acc.value = carry ? carry_in.value : '0;
        result.acc.ovf   = carry ? carry_in.ovf : 1'b0;
        pos = '0;
        for (int k = 0; k <= IDX; k++) begin
            if (4'(k) >= start) begin
                raw = carry ? ({1'b0, carry_in.seen} + 4'(k)) : (4'(k) - start);
                pos = (raw > 4'(vwd_pkg::MAX_VARINT_BYTES)) ?
                      3'(vwd_pkg::MAX_VARINT_BYTES) : raw[2:0];
                payload = data_bytes[vwd_pkg::BYTE_BITS * k +: 7] & vwd_pkg::PAYLOAD_MASK;
                shamt   = 6'(pos) * 6'(vwd_pkg::PAYLOAD_BITS);
                if (pos < 3'(vwd_pkg::MAX_VARINT_BYTES)) begin
                    result.acc.value = result.acc.value | ({25'd0, payload} << shamt);
                end else begin
                    result.acc.ovf = 1'b1;
                end
            end
        end

        result.acc.seen = (pos == 3'(vwd_pkg::MAX_VARINT_BYTES)) ? pos : pos + 3'd1;
        result.term = (4'(IDX) < byte_count) &&
                      !data_bytes[vwd_pkg::BYTE_BITS * IDX + 7];
    end

endmodule

`default_nettype wire

[hdl/vwd_merge.sv]
// Result buffer: holds the results of one word and sends them in byte order.
// Depends on vwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vwd_merge #(
    parameter int LANES = 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    load,
    input  wire logic [LANES:0]          load_mask,
    input  wire vwd_pkg::entry_t [LANES:0] load_entries,
    output logic                         can_load,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output vwd_pkg::out_item_t           m_data
);

    localparam int SEL_W = $clog2(LANES + 1);

    logic [LANES:0]            mask_reg;
    logic [LANES:0]            mask_next;
    vwd_pkg::entry_t [LANES:0] entry_reg;
    logic [SEL_W-1:0]          sel;
    logic                      last;
    logic                      pop;

    always_comb begin
        sel = '0;
        for (int i = LANES; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = SEL_W'(i);
            end
        end
    end

    assign last     = (mask_reg & (mask_reg - (LANES + 1)'(1))) == '0;
    assign m_valid  = |mask_reg;
    assign pop      = m_valid && m_ready;
    assign can_load = !m_valid || (pop && last);

    assign m_data.decoded_value = entry_reg[sel].value;
    assign m_data.status        = entry_reg[sel].status;
    assign m_data.last_of_word  = last;

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = load_mask;
        end else if (pop) begin
            mask_next = mask_reg & (mask_reg - (LANES + 1)'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= load_entries;
        end
    end

`ifndef ASSERT_OFF
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("loaded results not presented");
    a_more_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !last && !load) |=> m_valid)
        else $error("results lost before last of word");
    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && last && !load) |=> !m_valid)
        else $error("result repeated after last of word");
    a_load_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> can_load)
        else $error("results overwritten");
`endif

endmodule

`default_nettype wire

[hdl/varint_word_decoder.sv]
// Top level of the varint word decoder: lanes, open-varint state, result buffer.
// Depends on vwd_pkg, vwd_lane and vwd_merge.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   s_valid/s_ready/s_data carry one word of up to eight LEB128 stream bytes,
//   first byte in bits 7:0, with its byte count and end-of-stream mark.
//   m_valid/m_ready/m_data carry one decoded 32-bit value per finished varint,
//   in byte order, plus one cut-off result when the stream ends mid-varint.
//   last_of_word marks the final result of a word; a word may give none.
// Results of a word are registered and appear in the cycle after it is accepted.
// Words are taken one per cycle while each word gives at most one result and the
//   receiver is ready; a word giving N results holds the result port until the
//   single result register has drained them, one entry per cycle while m_ready is high.
// All LANES byte decoders work on the word in the same cycle; the open varint
//   (partial value, byte count, overlong mark) is carried in registers.
// Reset clears the open varint and the result buffer; no results pending.
// When the receiver stalls, the current result holds and the next word is
//   taken only in the cycle the last buffered result leaves.
module varint_word_decoder #(
    parameter int LANES = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire vwd_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output vwd_pkg::out_item_t       m_data
);

    vwd_pkg::varint_state_t         state_reg;
    vwd_pkg::varint_state_t         state_next;
    vwd_pkg::varint_state_t         open_state;
    vwd_pkg::lane_result_t [LANES-1:0] lanes;
    vwd_pkg::entry_t [LANES:0]      entries;
    logic [LANES:0]                 mask;
    logic [3:0]                     count_eff;
    logic                           accept;
    logic                           can_load;

    assign count_eff = (s_data.byte_count > 4'(LANES)) ? 4'(LANES) : s_data.byte_count;
    assign accept    = s_valid && s_ready;
    assign s_ready   = can_load;

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        vwd_lane #(
            .IDX (j)
        ) u_lane (
            .data_bytes (s_data.data_bytes),
            .byte_count (count_eff),
            .carry_in   (state_reg),
            .result     (lanes[j])
        );
    end

    always_comb begin
        open_state = state_reg;
        for (int j = 0; j < LANES; j++) begin
            if (4'(j) < count_eff) begin
                open_state = lanes[j].term ? '0 : lanes[j].acc;
            end
        end

        for (int j = 0; j < LANES; j++) begin
            mask[j]           = lanes[j].term;
            entries[j].value  = lanes[j].acc.value;
            entries[j].status = lanes[j].acc.ovf ? vwd_pkg::STATUS_OVERLONG
                                                 : vwd_pkg::STATUS_OK;
        end
        mask[LANES]           = s_data.end_of_stream && (open_state.seen != '0);
        entries[LANES].value  = open_state.value;
        entries[LANES].status = vwd_pkg::STATUS_CUTOFF;

        state_next = state_reg;
        if (accept) begin
            state_next = s_data.end_of_stream ? '0 : open_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    vwd_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept && (|mask)),
        .load_mask    (mask),
        .load_entries (entries),
        .can_load     (can_load),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

`ifndef ASSERT_OFF
    a_eos_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.end_of_stream) |=> (state_reg == '0))
        else $error("open varint survives end of stream");
    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.seen <= 3'(vwd_pkg::MAX_VARINT_BYTES))
        else $error("byte count of open varint out of range");
`endif

endmodule

`default_nettype wire

[sim/varint_word_decoder_checker.sv]
// Checker for the varint word decoder: watches both channels, decodes each
// accepted word on its own and compares the results in order.
// Depends on vwd_pkg for the item types and the status codes.
`timescale 1ns / 1ps

module varint_word_decoder_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire vwd_pkg::in_item_t  s_data,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire vwd_pkg::out_item_t m_data,
    output int                      mismatch_count,
    output int                      results_pending
);

    vwd_pkg::out_item_t decoded_q[$];
    logic [31:0]        open_value;
    logic [2:0]         open_bytes;
    logic               open_overlong;
    int                 fails = 0;
    int                 pending_count = 0;

    assign mismatch_count  = fails;
    assign results_pending = pending_count;

    task automatic clear_open_varint();
        open_value    = '0;
        open_bytes    = '0;
        open_overlong = 1'b0;
    endtask

    task automatic push_value(input logic [1:0] status);
        vwd_pkg::out_item_t r;
        r.decoded_value = open_value;
        r.status        = status;
        r.last_of_word  = 1'b0;
        decoded_q.push_back(r);
        clear_open_varint();
    endtask

    task automatic decode_word(input vwd_pkg::in_item_t word);
        int                 lanes;
        int                 first_new;
        logic [7:0]         b;
        logic [31:0]        payload;
        vwd_pkg::out_item_t r;
        lanes     = (word.byte_count > vwd_pkg::WORD_BYTES) ? vwd_pkg::WORD_BYTES
                                                            : int'(word.byte_count);
        first_new = decoded_q.size();
        for (int i = 0; i < lanes; i++) begin
            b       = word.data_bytes[vwd_pkg::BYTE_BITS*i +: vwd_pkg::BYTE_BITS];
            payload = {25'd0, b[6:0] & vwd_pkg::PAYLOAD_MASK};
            if (open_bytes < vwd_pkg::MAX_VARINT_BYTES) begin
                open_value = open_value | (payload << (vwd_pkg::PAYLOAD_BITS * open_bytes));
                open_bytes = open_bytes + 3'd1;
            end else begin
                open_overlong = 1'b1;
            end
            if (!b[7]) begin
                push_value(open_overlong ? vwd_pkg::STATUS_OVERLONG : vwd_pkg::STATUS_OK);
            end
        end
        if (word.end_of_stream && open_bytes != 0) begin
            push_value(vwd_pkg::STATUS_CUTOFF);
        end
        if (decoded_q.size() > first_new) begin
            r = decoded_q.pop_back();
            r.last_of_word = 1'b1;
            decoded_q.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        vwd_pkg::out_item_t want;
        if (!aresetn) begin
            decoded_q.delete();
            clear_open_varint();
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("decoded_value: expected none, actual %0h (status %0d)",
                           m_data.decoded_value, m_data.status);
                    fails++;
                end else begin
                    want = decoded_q.pop_front();
                    compare_field("decoded_value", want.decoded_value,
                                  m_data.decoded_value);
                    compare_field("status", 32'(want.status), 32'(m_data.status));
                    compare_field("last_of_word", 32'(want.last_of_word),
                                  32'(m_data.last_of_word));
                end
            end
            if (s_valid && s_ready) begin
                decode_word(s_data);
            end
        end
        pending_count = decoded_q.size();
    end

endmodule

[sim/varint_word_decoder_tb.sv]
// Testbench top for the varint word decoder: clock, reset, word stimulus and
// result-side stalls. Depends on vwd_pkg, varint_word_decoder and the checker.
`timescale 1ns / 1ps

module varint_word_decoder_tb;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    vwd_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready = 1'b0;
    vwd_pkg::out_item_t m_data;
    int                 mismatch_count;
    int                 results_pending;
    int                 send_idle_pct = 9;
    int                 recv_idle_pct = 60;
    int                 varint_left = 0;

    varint_word_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    varint_word_decoder_checker decode_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3ms;
        $display("varint_word_decoder_tb NOT OK");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_word(input logic [63:0] data, input logic [3:0] count,
                             input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_bytes: data, byte_count: count, end_of_stream: eos};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Bytes of a well-formed stream; mostly up to five bytes, some overlong.
    function automatic logic [7:0] next_stream_byte();
        logic [7:0] b;
        if (varint_left == 0) begin
            varint_left = ($urandom_range(9) == 0) ? $urandom_range(10, 6)
                                                   : $urandom_range(5, 1);
        end
        b = 8'($urandom_range(255));
        varint_left--;
        b[7] = (varint_left != 0);
        return b;
    endfunction

    task automatic send_random_word();
        logic [63:0] data;
        int          count;
        int          lanes;
        int          pick;
        logic        eos;
        pick = $urandom_range(99);
        if (pick < 5) begin
            count = 0;
        end else if (pick < 12) begin
            count = $urandom_range(15, 9);
        end else begin
            count = $urandom_range(8, 1);
        end
        data = {$urandom, $urandom};
        eos  = ($urandom_range(19) == 0);
        if ($urandom_range(99) >= 15) begin
            lanes = (count > vwd_pkg::WORD_BYTES) ? vwd_pkg::WORD_BYTES : count;
            for (int i = 0; i < lanes; i++) begin
                data[vwd_pkg::BYTE_BITS*i +: vwd_pkg::BYTE_BITS] = next_stream_byte();
            end
        end
        if (eos) begin
            varint_left = 0;
        end
        send_word(data, 4'(count), eos);
    endtask

    initial begin
        int drain_cycles;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(64'h0000_0000_0000_0000, 4'd1, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FF7F, 4'd1, 1'b0);
        send_word(64'h7F00_0140_7F00_0102, 4'd8, 1'b0);
        send_word(64'h0000_000F_FFFF_FFFF, 4'd5, 1'b0);
        send_word(64'h0000_0070_8080_8080, 4'd5, 1'b0);
        send_word(64'h01FF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
        // varint spliced across two words
        send_word(64'h0000_0000_0080_8081, 4'd3, 1'b0);
        send_word(64'h0000_0000_0000_0281, 4'd2, 1'b0);
        // overlong, then flushed by an empty end-of-stream word
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
        send_word(64'h0000_0000_0000_0000, 4'd0, 1'b1);
        send_word(64'h0000_0000_0000_0000, 4'd0, 1'b1);
        send_word(64'h0000_0000_0000_0000, 4'd0, 1'b0);
        send_word(64'h0000_0000_0000_8505, 4'd2, 1'b1);
        send_word(64'h0101_0101_0101_0101, 4'd15, 1'b0);
        send_word(64'h0000_0000_0000_0000, 4'd8, 1'b0);
        send_word(64'h8080_8080_8080_8080, 4'd9, 1'b0);
        send_word(64'h0000_0000_0000_0000, 4'd1, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FF85, 4'd1, 1'b1);
        send_word(64'h8000_0000_0000_0000, 4'd8, 1'b0);
        send_word(64'h0000_0000_0000_007F, 4'd1, 1'b1);

        repeat (54) send_random_word();
        send_idle_pct = 60;
        recv_idle_pct = 9;
        repeat (54) send_random_word();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (54) send_random_word();
        s_valid <= 1'b0;

        drain_cycles = 0;
        @(negedge aclk);
        while (results_pending != 0 && drain_cycles < 100000) begin
            @(negedge aclk);
            drain_cycles++;
        end
        repeat (4) @(negedge aclk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("varint_word_decoder_tb OK");
        end else begin
            $display("varint_word_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule
